@@ rtl/assert_macros.svh @@
// assertion macros for the date arithmetic block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on the block clock, off during reset
`define GDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define GDA_ASSERT_IMP(lbl, ante, cons, msg) \
  `GDA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/gda_pkg.sv @@
// shared types, constants and calendar functions for the date arithmetic block
`default_nettype none
package gda_pkg;

  localparam logic [22:0] DayMax   = 23'd3652424;
  localparam logic [21:0] ApartMax = 22'h3FFFFF;
  localparam logic [13:0] YearMax  = 14'd9999;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_APART = 2'd2,
    CMD_CMP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic        conv;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [21:0] apart;
    logic        is_before;
    logic        equal;
    logic        after;
    logic        oor;
  } meta_t;

  // floor(x / 100) by reciprocal, exact for x below 25600
  function automatic logic [7:0] div100(input logic [15:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd5243;
    return p[26:19];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0]  q;
    logic [14:0] h;
    q = div100(16'(y));
    h = 15'(q) * 15'd100;
    return (y[1:0] == 2'b00) && ((h != 15'(y)) || (q[1:0] == 2'b00));
  endfunction

  // days from 0000-01-01 to the first day of year y
  function automatic logic [22:0] ystart(input logic [13:0] y);
    logic [22:0] a;
    logic [13:0] c4;
    logic [7:0]  q1;
    logic [7:0]  q4;
    a  = 23'(y) * 23'd365;
    c4 = 14'((15'(y) + 15'd3) >> 2);
    q1 = div100(16'(y) + 16'd99);
    q4 = div100(16'(y) + 16'd399);
    return a + 23'(c4) - 23'(q1) + 23'(q4[7:2]);
  endfunction

  function automatic logic [8:0] mstart(input logic [3:0] m, input logic lp);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s + 9'((lp && (m > 4'd2)) ? 1 : 0);
  endfunction

  function automatic logic [4:0] dim(input logic [3:0] m, input logic lp);
    logic [4:0] n;
    case (m)
      4'd2:                   n = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/gda_daynum.sv @@
// two-stage date normalization and conversion to a day number
`default_nettype none
module gda_daynum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  output logic        valid_o,
  output logic [22:0] daynum_o,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o
);
  import gda_pkg::*;

  logic        v1_q, v2_q;
  logic [13:0] y1_q, y1_d;
  logic [3:0]  m1_q, m1_d;
  logic [4:0]  d1_q, d1_d;
  logic        lp1_q, lp1_d;
  logic [22:0] ys1_q, ys1_d;
  logic [22:0] n2_q, n2_d;
  logic [13:0] y2_q;
  logic [3:0]  m2_q;
  logic [4:0]  d2_q;
  logic [4:0]  len;

  always_comb begin
    y1_d  = year_i;
    lp1_d = is_leap(year_i);
    ys1_d = ystart(year_i);
    if (month_i < 4'd1) begin
      m1_d = 4'd1;
    end else if (month_i > 4'd12) begin
      m1_d = 4'd12;
    end else begin
      m1_d = month_i;
    end
    len = dim(m1_d, lp1_d);
    if (day_i < 5'd1) begin
      d1_d = 5'd1;
    end else if (day_i > len) begin
      d1_d = len;
    end else begin
      d1_d = day_i;
    end
  end

  assign n2_d = ys1_q + 23'(mstart(m1_q, lp1_q)) + 23'(d1_q) - 23'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y1_q  <= y1_d;
    m1_q  <= m1_d;
    d1_q  <= d1_d;
    lp1_q <= lp1_d;
    ys1_q <= ys1_d;
    n2_q  <= n2_d;
    y2_q  <= y1_q;
    m2_q  <= m1_q;
    d2_q  <= d1_q;
  end

  assign valid_o  = v2_q;
  assign daynum_o = n2_q;
  assign year_o   = y2_q;
  assign month_o  = m2_q;
  assign day_o    = d2_q;
endmodule
`default_nettype wire

@@ rtl/gda_fromday.sv @@
// four-stage day number to date conversion and result register
`default_nettype none
module gda_fromday (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [21:0]     daynum_i,
  input  gda_pkg::meta_t  meta_i,
  output logic            valid_o,
  output logic [13:0]     res_year_o,
  output logic [3:0]      res_month_o,
  output logic [4:0]      res_day_o,
  output logic [21:0]     days_apart_o,
  output logic            a_before_b_o,
  output logic            dates_equal_o,
  output logic            a_after_b_o,
  output logic            out_of_range_o
);
  import gda_pkg::*;

  logic        v1_q, v2_q, v3_q, vo_q;
  meta_t       m1_q, m2_q, m3_q, mo_q;
  logic [21:0] n1_q, n2_q;
  logic [13:0] base1_q, base1_d, base2_q;
  logic [37:0] prod;
  logic [13:0] est;
  logic [22:0] s2_q [5];
  logic [22:0] s2_d [5];
  logic        l2_q [5];
  logic        l2_d [5];
  logic [2:0]  k;
  logic [13:0] y3_q, y3_d;
  logic [8:0]  r3_q, r3_d;
  logic        lp3_q, lp3_d;
  logic [3:0]  mm;
  logic [8:0]  st;
  logic [13:0] yo_q, yo_d;
  logic [3:0]  mo_mq, mo_md;
  logic [4:0]  do_q, do_d;

  // year estimate from n * 400 / 146097, low by at most two
  always_comb begin
    prod = 38'(daynum_i) * 38'd45934;
    est  = prod[37:24];
    base1_d = (est >= 14'd2) ? est - 14'd2 : 14'd0;
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      s2_d[i] = ystart(base1_q + 14'(i));
      l2_d[i] = is_leap(base1_q + 14'(i));
    end
  end

  always_comb begin
    k = 3'd0;
    for (int i = 1; i < 5; i++) begin
      if (s2_q[i] <= 23'(n2_q)) begin
        k = 3'(i);
      end
    end
    y3_d  = base2_q + 14'(k);
    r3_d  = 9'(23'(n2_q) - s2_q[k]);
    lp3_d = l2_q[k];
  end

  always_comb begin
    mm = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (mstart(4'(i), lp3_q) <= r3_q) begin
        mm = 4'(i);
      end
    end
    st = mstart(mm, lp3_q);
    if (m3_q.conv) begin
      yo_d  = y3_q;
      mo_md = mm;
      do_d  = 5'(r3_q - st) + 5'd1;
    end else begin
      yo_d  = m3_q.y;
      mo_md = m3_q.m;
      do_d  = m3_q.d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= meta_i;
    n1_q    <= daynum_i;
    base1_q <= base1_d;
    m2_q    <= m1_q;
    n2_q    <= n1_q;
    base2_q <= base1_q;
    s2_q    <= s2_d;
    l2_q    <= l2_d;
    m3_q    <= m2_q;
    y3_q    <= y3_d;
    r3_q    <= r3_d;
    lp3_q   <= lp3_d;
    mo_q    <= m3_q;
    yo_q    <= yo_d;
    mo_mq   <= mo_md;
    do_q    <= do_d;
  end

  assign valid_o        = vo_q;
  assign res_year_o     = yo_q;
  assign res_month_o    = mo_mq;
  assign res_day_o      = do_q;
  assign days_apart_o   = mo_q.apart;
  assign a_before_b_o   = mo_q.is_before;
  assign dates_equal_o  = mo_q.equal;
  assign a_after_b_o    = mo_q.after;
  assign out_of_range_o = mo_q.oor;
endmodule
`default_nettype wire

@@ rtl/gregorian_date_arithmetic.sv @@
// top level of the Gregorian date arithmetic block
//
// one command channel in, one result channel out. a transaction is taken at
// a rising edge with start_i high and busy_o low; busy_o is always low, so
// a new transaction may be issued in every cycle.
// each transaction carries two dates, a day count and a command: add, subtract,
// days between, or compare only. the result always carries the ordering flags.
// the result appears on the result ports for one cycle, marked by valid_o.
// between the rising edge that takes a transaction and its result lie seven
// register stages: two for date to day number, one for the shift and compare,
// four for day number to date (year estimate, candidate year starts, year
// select, month select).
// throughput is one transaction per cycle.
// the receiver cannot stall, so results are never held.
// reset clears all valid bits; transactions in flight are dropped.
`default_nettype none
module gregorian_date_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [13:0] a_year_i,
  input  logic [3:0]  a_month_i,
  input  logic [4:0]  a_day_i,
  input  logic [13:0] b_year_i,
  input  logic [3:0]  b_month_i,
  input  logic [4:0]  b_day_i,
  input  logic [19:0] day_count_i,
  output logic        valid_o,
  output logic [13:0] res_year_o,
  output logic [3:0]  res_month_o,
  output logic [4:0]  res_day_o,
  output logic [21:0] days_apart_o,
  output logic        a_before_b_o,
  output logic        dates_equal_o,
  output logic        a_after_b_o,
  output logic        out_of_range_o
);
  import gda_pkg::*;

  logic        acc;
  logic        va, vb;
  logic [22:0] na, nb;
  logic [13:0] ay, by;
  logic [3:0]  am, bm;
  logic [4:0]  ad, bd;
  cmd_e        cmd1_q, cmd2_q;
  logic [19:0] cnt1_q, cnt2_q;
  logic        v3_q;
  meta_t       meta_q, meta_d;
  logic [21:0] n3_q, n3_d;
  logic [23:0] sum;
  logic [22:0] sub;
  logic [22:0] gap;
  logic [2:0]  order_flags;
  logic        sat_ok;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  gda_daynum u_day_a (
    .clk_i, .rst_ni, .valid_i(acc),
    .year_i(a_year_i), .month_i(a_month_i), .day_i(a_day_i),
    .valid_o(va), .daynum_o(na), .year_o(ay), .month_o(am), .day_o(ad)
  );

  gda_daynum u_day_b (
    .clk_i, .rst_ni, .valid_i(acc),
    .year_i(b_year_i), .month_i(b_month_i), .day_i(b_day_i),
    .valid_o(vb), .daynum_o(nb), .year_o(by), .month_o(bm), .day_o(bd)
  );

  always_comb begin
    sum  = 24'(na) + 24'(cnt2_q);
    sub  = na - 23'(cnt2_q);
    gap  = (na > nb) ? na - nb : nb - na;
    n3_d = '0;
    meta_d           = '0;
    meta_d.y         = ay;
    meta_d.m         = am;
    meta_d.d         = ad;
    meta_d.is_before = (na < nb);
    meta_d.equal     = (na == nb);
    meta_d.after     = (na > nb);
    case (cmd2_q)
      CMD_ADD: begin
        if (sum > 24'(DayMax)) begin
          meta_d.oor = 1'b1;
          meta_d.y = YearMax; meta_d.m = 4'd12; meta_d.d = 5'd31;
        end else begin
          meta_d.conv = 1'b1;
          n3_d = sum[21:0];
        end
      end
      CMD_SUB: begin
        if (23'(cnt2_q) > na) begin
          meta_d.oor = 1'b1;
          meta_d.y = 14'd0; meta_d.m = 4'd1; meta_d.d = 5'd1;
        end else if (sub > DayMax) begin
          meta_d.oor = 1'b1;
          meta_d.y = YearMax; meta_d.m = 4'd12; meta_d.d = 5'd31;
        end else begin
          meta_d.conv = 1'b1;
          n3_d = sub[21:0];
        end
      end
      CMD_APART: begin
        meta_d.apart = (gap > 23'(ApartMax)) ? ApartMax : gap[21:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= va && vb;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= cmd_e'(cmd_i);
    cnt1_q <= day_count_i;
    cmd2_q <= cmd1_q;
    cnt2_q <= cnt1_q;
    meta_q <= meta_d;
    n3_q   <= n3_d;
  end

  gda_fromday u_from (
    .clk_i, .rst_ni, .valid_i(v3_q), .daynum_i(n3_q), .meta_i(meta_q),
    .valid_o, .res_year_o, .res_month_o, .res_day_o, .days_apart_o,
    .a_before_b_o, .dates_equal_o, .a_after_b_o, .out_of_range_o
  );

  assign order_flags = {a_before_b_o, dates_equal_o, a_after_b_o};
  assign sat_ok = (res_year_o == YearMax && res_month_o == 4'd12 && res_day_o == 5'd31) ||
                  (res_year_o == 14'd0 && res_month_o == 4'd1 && res_day_o == 5'd1);

`include "assert_macros.svh"

  `GDA_ASSERT_IMP(a_order_onehot, valid_o, $onehot(order_flags), "ordering flags not one-hot")
  `GDA_ASSERT_IMP(a_sat_date, valid_o && out_of_range_o, sat_ok, "saturated date wrong")
  `GDA_ASSERT_IMP(a_apart_equal, valid_o && dates_equal_o, days_apart_o == 22'd0, "apart not 0")
  `GDA_ASSERT(a_latency, $past(acc, 7) |-> valid_o, "result strobe missing")

endmodule
`default_nettype wire
